/* rtl/lkd_pkg.sv */
// Shared types and constants for the LED/key driver I2C master.
package lkd_pkg;

   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;
   localparam int CMD_SHIFT = 7;

   localparam logic [7:0] READ_BIT = 8'h01;
   localparam logic [6:0] WRITE_LAST_STEP = 7'd64;
   localparam logic [6:0] READ_LAST_STEP = 7'd74;

   localparam logic [7:0] DEVICE_ADDRESS_RESET = 8'd64;
   localparam logic [7:0] ADDRESS_MASK_RESET = 8'd62;
   localparam logic [15:0] KEY_COMMAND_RESET = 16'd1792;
   localparam logic [7:0] PHASE_TICKS_RESET = 8'd1;

   typedef enum logic [1:0] {
      CMD_TICK = 2'd0,
      CMD_WRITE = 2'd1,
      CMD_READ = 2'd2
   } cmd_type;

   typedef enum logic [1:0] {
      REG_DEVICE_ADDRESS = 2'd0,
      REG_ADDRESS_MASK = 2'd1,
      REG_KEY_COMMAND = 2'd2,
      REG_PHASE_TICKS = 2'd3
   } reg_index_type;

   typedef enum logic [1:0] {
      OP_TICK = 2'd0,
      OP_WRITE = 2'd1,
      OP_READ = 2'd2
   } op_type;

   typedef struct packed {
      logic [1:0] cmd;
      logic [15:0] command_word;
      logic sda_in;
   } req_type;

   typedef struct packed {
      logic scl_level;
      logic sda_level;
      logic sda_drive;
      logic busy_res;
      logic key_valid;
      logic [7:0] key_code;
      logic rejected;
   } rsp_type;

   typedef struct packed {
      logic [7:0] device_address;
      logic [7:0] address_mask;
      logic [15:0] key_command;
      logic [7:0] phase_ticks;
   } cfg_type;

   typedef struct packed {
      op_type op;
      logic [7:0] addr_byte;
      logic [7:0] data_byte;
      logic sda_in;
   } entry_type;

endpackage

/* rtl/lkd_csr.sv */
// Configuration register file behind the APB-style port.
module lkd_csr
   import lkd_pkg::*;
(
   input logic clock,
   input logic reset,
   input logic csr_psel,
   input logic csr_penable,
   input logic csr_pwrite,
   input logic [CSR_ADDR_W-1:0] csr_paddr,
   input logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic csr_pready,
   output cfg_type cfg
);

   cfg_type cfg_ff, cfg_in;
   logic wr_en;
   reg_index_type index;

   assign csr_pready = 1'b1;
   assign wr_en = csr_psel && csr_penable && csr_pwrite;
   assign index = reg_index_type'(csr_paddr[3:2]);
   assign cfg = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (index)
            REG_DEVICE_ADDRESS: cfg_in.device_address = csr_pwdata[7:0];
            REG_ADDRESS_MASK: cfg_in.address_mask = csr_pwdata[7:0];
            REG_KEY_COMMAND: cfg_in.key_command = csr_pwdata[15:0];
            REG_PHASE_TICKS: cfg_in.phase_ticks = csr_pwdata[7:0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (index)
         REG_DEVICE_ADDRESS: csr_prdata = {24'd0, cfg_ff.device_address};
         REG_ADDRESS_MASK: csr_prdata = {24'd0, cfg_ff.address_mask};
         REG_KEY_COMMAND: csr_prdata = {16'd0, cfg_ff.key_command};
         REG_PHASE_TICKS: csr_prdata = {24'd0, cfg_ff.phase_ticks};
         default: csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.device_address <= DEVICE_ADDRESS_RESET;
         cfg_ff.address_mask <= ADDRESS_MASK_RESET;
         cfg_ff.key_command <= KEY_COMMAND_RESET;
         cfg_ff.phase_ticks <= PHASE_TICKS_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

/* rtl/lkd_front.sv */
// Front end: accepts request words and turns them into sequencer operations.
module lkd_front
   import lkd_pkg::*;
(
   input logic req_valid,
   output logic req_ready,
   input req_type req_data,
   input cfg_type cfg,
   output logic push_valid,
   input logic push_ready,
   output entry_type push_entry
);

   logic [7:0] write_addr;
   logic [7:0] read_addr;

   assign req_ready = push_ready;
   assign push_valid = req_valid;

   assign write_addr = (req_data.command_word[CMD_SHIFT +: 8] & cfg.address_mask)
                       | cfg.device_address;
   assign read_addr = (cfg.key_command[CMD_SHIFT +: 8] & cfg.address_mask)
                      | READ_BIT | cfg.device_address;

   always_comb begin
      push_entry.sda_in = req_data.sda_in;
      case (req_data.cmd)
         CMD_WRITE: begin
            push_entry.op = OP_WRITE;
            push_entry.addr_byte = write_addr;
            push_entry.data_byte = req_data.command_word[7:0];
         end
         CMD_READ: begin
            push_entry.op = OP_READ;
            push_entry.addr_byte = read_addr;
            push_entry.data_byte = 8'd0;
         end
         default: begin
            push_entry.op = OP_TICK;
            push_entry.addr_byte = write_addr;
            push_entry.data_byte = req_data.command_word[7:0];
         end
      endcase
   end

endmodule

/* rtl/lkd_queue.sv */
// Short queue that decouples the front end from the bus sequencer.
module lkd_queue
   import lkd_pkg::*;
#(
   parameter int DEPTH = 2
)
(
   input logic clock,
   input logic reset,
   input logic push_valid,
   output logic push_ready,
   input entry_type push_entry,
   output logic pop_valid,
   input logic pop_ready,
   output entry_type pop_entry
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   entry_type entries_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic push, pop;

   assign push_ready = (count_ff != CNT_W'(DEPTH));
   assign pop_valid = (count_ff != '0);
   assign pop_entry = entries_ff[rd_ptr_ff];
   assign push = push_valid && push_ready;
   assign pop = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

endmodule

/* rtl/lkd_back.sv */
// Back end: the I2C phase sequencer and the registered result word.
module lkd_back
   import lkd_pkg::*;
(
   input logic clock,
   input logic reset,
   input cfg_type cfg,
   input logic pop_valid,
   output logic pop_ready,
   input entry_type pop_entry,
   output logic rsp_valid,
   input logic rsp_ready,
   output rsp_type rsp_data
);

   typedef struct packed {
      logic scl;
      logic sda;
      logic drv;
      logic smp;
   } lvl_type;

   function automatic lvl_type start_phase(input logic [1:0] q);
      lvl_type l;
      l.drv = 1'b1;
      l.smp = 1'b0;
      case (q)
         2'd0, 2'd1: begin l.scl = 1'b1; l.sda = 1'b1; end
         2'd2: begin l.scl = 1'b1; l.sda = 1'b0; end
         default: begin l.scl = 1'b0; l.sda = 1'b0; end
      endcase
      return l;
   endfunction

   function automatic lvl_type stop_phase(input logic [1:0] q);
      lvl_type l;
      l.drv = 1'b1;
      l.smp = 1'b0;
      case (q)
         2'd0: begin l.scl = 1'b0; l.sda = 1'b1; end
         2'd1: begin l.scl = 1'b0; l.sda = 1'b0; end
         2'd2: begin l.scl = 1'b1; l.sda = 1'b0; end
         default: begin l.scl = 1'b1; l.sda = 1'b1; end
      endcase
      return l;
   endfunction

   function automatic lvl_type write_phase(input logic [4:0] q, input logic [7:0] byte_v);
      lvl_type l;
      logic [7:0] prod;
      logic [2:0] bit_idx;
      logic [1:0] sub;
      prod = {3'd0, q} * 8'd11;
      bit_idx = prod[7:5];
      sub = 2'(q - {2'd0, bit_idx} * 5'd3);
      l.drv = 1'b1;
      l.smp = 1'b0;
      if (q < 5'd24) begin
         l.scl = (sub == 2'd1);
         l.sda = byte_v[3'd7 - bit_idx];
      end else begin
         case (q)
            5'd24: begin l.scl = 1'b0; l.sda = byte_v[0]; end
            5'd26: begin l.scl = 1'b1; l.sda = 1'b1; end
            default: begin l.scl = 1'b0; l.sda = 1'b1; end
         endcase
      end
      return l;
   endfunction

   function automatic lvl_type read_phase(input logic [5:0] q);
      lvl_type l;
      logic [1:0] r;
      r = 2'(q - 6'd3);
      l.sda = 1'b1;
      l.smp = 1'b0;
      if (q == 6'd0) begin
         l.scl = 1'b0;
         l.drv = 1'b1;
      end else if (q < 6'd3) begin
         l.scl = 1'b0;
         l.drv = 1'b0;
      end else if (q < 6'd35) begin
         l.scl = (r != 2'd3);
         l.drv = 1'b0;
         l.smp = (r == 2'd2);
      end else begin
         l.scl = (q == 6'd36);
         l.drv = 1'b1;
      end
      return l;
   endfunction

   function automatic lvl_type phase_of(input logic [6:0] p, input logic is_read,
                                        input logic [7:0] sb, input logic [7:0] db);
      lvl_type l;
      if (p < 7'd4) begin
         l = start_phase(p[1:0]);
      end else if (p < 7'd32) begin
         l = write_phase(5'(p - 7'd4), sb);
      end else if (!is_read) begin
         if (p < 7'd60) begin
            l = write_phase(5'(p - 7'd32), db);
         end else begin
            l = stop_phase(2'(p - 7'd60));
         end
      end else if (p < 7'd70) begin
         l = read_phase(6'(p - 7'd32));
      end else begin
         l = stop_phase(2'(p - 7'd70));
      end
      return l;
   endfunction

   logic [6:0] step_ff, step_in;
   logic [7:0] tick_ff, tick_in;
   logic kind_ff, kind_in;
   logic [7:0] shift_byte_ff, shift_byte_in;
   logic [7:0] second_byte_ff, second_byte_in;
   logic [7:0] read_byte_ff, read_byte_in;
   logic [2:0] line_ff, line_in;
   logic rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_data_ff, rsp_data_in;

   logic pop;
   logic start_req;
   logic rej;
   logic kv;
   logic busy;
   logic [6:0] step_w;
   logic [7:0] tick_w;
   logic [7:0] tick_inc;
   logic [7:0] pt;
   logic [6:0] last_step;
   lvl_type ph;

   assign pop_ready = !rsp_valid_ff || rsp_ready;
   assign pop = pop_valid && pop_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_data_ff;
   assign start_req = (pop_entry.op == OP_WRITE) || (pop_entry.op == OP_READ);
   assign pt = (cfg.phase_ticks == 8'd0) ? 8'd1 : cfg.phase_ticks;

   always_comb begin
      step_in = step_ff;
      tick_in = tick_ff;
      kind_in = kind_ff;
      shift_byte_in = shift_byte_ff;
      second_byte_in = second_byte_ff;
      read_byte_in = read_byte_ff;
      line_in = line_ff;
      rej = 1'b0;
      kv = 1'b0;
      busy = 1'b0;
      step_w = step_ff;
      tick_w = tick_ff;
      tick_inc = 8'd0;
      last_step = WRITE_LAST_STEP;
      ph = '0;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in = rsp_data_ff;

      if (pop) begin
         if (start_req) begin
            if (step_ff != 7'd0) begin
               rej = 1'b1;
            end else begin
               kind_in = (pop_entry.op == OP_READ);
               shift_byte_in = pop_entry.addr_byte;
               second_byte_in = pop_entry.data_byte;
               step_w = 7'd1;
               tick_w = 8'd0;
            end
         end
         step_in = step_w;
         tick_in = tick_w;
         if (step_w != 7'd0) begin
            ph = phase_of(step_w - 7'd1, kind_in, shift_byte_in, second_byte_in);
            last_step = kind_in ? READ_LAST_STEP : WRITE_LAST_STEP;
            busy = 1'b1;
            line_in = {ph.drv, ph.sda, ph.scl};
            if (ph.smp && (tick_w == 8'd0)) begin
               second_byte_in = {second_byte_in[6:0], pop_entry.sda_in};
            end
            tick_inc = tick_w + 8'd1;
            tick_in = tick_inc;
            if (tick_inc >= pt) begin
               tick_in = 8'd0;
               if (step_w >= last_step) begin
                  step_in = 7'd0;
                  if (kind_in) begin
                     read_byte_in = second_byte_in;
                     kv = 1'b1;
                  end
               end else begin
                  step_in = step_w + 7'd1;
               end
            end
         end
         rsp_valid_in = 1'b1;
         rsp_data_in.scl_level = line_in[0];
         rsp_data_in.sda_level = line_in[1];
         rsp_data_in.sda_drive = line_in[2];
         rsp_data_in.busy_res = busy;
         rsp_data_in.key_valid = kv;
         rsp_data_in.key_code = read_byte_in;
         rsp_data_in.rejected = rej;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      if (reset) begin
         step_ff <= '0;
         tick_ff <= '0;
         kind_ff <= 1'b0;
         shift_byte_ff <= '0;
         second_byte_ff <= '0;
         read_byte_ff <= '0;
         line_ff <= 3'b111;
         rsp_valid_ff <= 1'b0;
      end else begin
         step_ff <= step_in;
         tick_ff <= tick_in;
         kind_ff <= kind_in;
         shift_byte_ff <= shift_byte_in;
         second_byte_ff <= second_byte_in;
         read_byte_ff <= read_byte_in;
         line_ff <= line_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

`ifndef ASSERT_OFF
   a_step_range: assert property (@(posedge clock) disable iff (reset)
      step_ff <= READ_LAST_STEP)
      else $error("sequence step beyond the last read phase");

   a_reject_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff.rejected |-> rsp_data_ff.busy_res)
      else $error("start rejected while the sequencer was idle");

   a_key_done_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff.key_valid |-> step_ff == 7'd0 && kind_ff)
      else $error("key word reported while a read is still running");

   a_released_high: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_data_ff.sda_drive |-> rsp_data_ff.sda_level)
      else $error("released data line not reported at the pulled-up level");
`endif

endmodule

/* rtl/led_key_driver_i2c_master.sv */
// Top level of the I2C master for an LED/key driver chip.
//
//   Port group   Direction   Handshake                 Payload
//   req_         in          req_valid / req_ready     req_data (req_type)
//   rsp_         out         rsp_valid / rsp_ready     rsp_data (rsp_type)
//   csr_         in/out      csr_psel / csr_penable    csr_paddr, csr_pwdata, csr_prdata
//
// One request word is taken per clock while the queue has room, and each one gives one result word.
// A request is held in the queue, and its result is held in the sequencer's
// output register.
// Reset is synchronous; it clears the queue and the sequencer and loads the registers with their reset values.
// A stalled result holds the sequencer, and the queue keeps accepting until full.
module led_key_driver_i2c_master
   import lkd_pkg::*;
#(
   parameter int QUEUE_DEPTH = 2
)
(
   input logic clock,
   input logic reset,
   input logic req_valid,
   output logic req_ready,
   input req_type req_data,
   output logic rsp_valid,
   input logic rsp_ready,
   output rsp_type rsp_data,
   input logic csr_psel,
   input logic csr_penable,
   input logic csr_pwrite,
   input logic [CSR_ADDR_W-1:0] csr_paddr,
   input logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic csr_pready
);

   cfg_type cfg;
   logic push_valid, push_ready;
   entry_type push_entry;
   logic pop_valid, pop_ready;
   entry_type pop_entry;

   lkd_csr u_csr (
      .clock(clock),
      .reset(reset),
      .csr_psel(csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr),
      .csr_pwdata(csr_pwdata),
      .csr_prdata(csr_prdata),
      .csr_pready(csr_pready),
      .cfg(cfg)
   );

   lkd_front u_front (
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data(req_data),
      .cfg(cfg),
      .push_valid(push_valid),
      .push_ready(push_ready),
      .push_entry(push_entry)
   );

   lkd_queue #(
      .DEPTH(QUEUE_DEPTH)
   ) u_queue (
      .clock(clock),
      .reset(reset),
      .push_valid(push_valid),
      .push_ready(push_ready),
      .push_entry(push_entry),
      .pop_valid(pop_valid),
      .pop_ready(pop_ready),
      .pop_entry(pop_entry)
   );

   lkd_back u_back (
      .clock(clock),
      .reset(reset),
      .cfg(cfg),
      .pop_valid(pop_valid),
      .pop_ready(pop_ready),
      .pop_entry(pop_entry),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data(rsp_data)
   );

endmodule
